// ===== sv/rlp_pkg.sv =====
// Types, codes and helpers shared by the request-line parser modules.
package rlp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int          RES_W   = 13;
  localparam int          VER_W   = 16;
  localparam logic [19:0] VER_MAX = 20'd65535;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_LF   = 3'd1;
  localparam logic [2:0] ST_SPACING = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;

  typedef enum logic [9:0] {
    PH_H1    = 10'b00_0000_0001,
    PH_T1    = 10'b00_0000_0010,
    PH_T2    = 10'b00_0000_0100,
    PH_P     = 10'b00_0000_1000,
    PH_SLASH = 10'b00_0001_0000,
    PH_MAJ0  = 10'b00_0010_0000,
    PH_MAJ   = 10'b00_0100_0000,
    PH_MIN0  = 10'b00_1000_0000,
    PH_MIN   = 10'b01_0000_0000,
    PH_FAIL  = 10'b10_0000_0000
  } ver_phase_t;

  typedef struct packed {
    ver_phase_t         phase;
    logic [VER_W-1:0]   major;
    logic [VER_W-1:0]   minor;
  } ver_t;

  function automatic logic [VER_W-1:0] sat_digit(logic [VER_W-1:0] acc, logic [3:0] d);
    logic [19:0] v;
    v = (20'(acc) << 3) + (20'(acc) << 1) + 20'(d);
    return (v > VER_MAX) ? VER_MAX[VER_W-1:0] : v[VER_W-1:0];
  endfunction

endpackage

// ===== sv/rlp_version.sv =====
// Next-state logic of the HTTP/major.minor version matcher.
module rlp_version import rlp_pkg::*; (
  input  ver_t       cur,
  input  logic [7:0] byte_in,
  output ver_t       nxt
);

  logic       dig;
  logic [3:0] dval;

  assign dig  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign dval = dig ? 4'(byte_in - CH_ZERO) : 4'd0;

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_H1:    nxt.phase = (byte_in == CH_H) ? PH_T1 : PH_FAIL;
      PH_T1:    nxt.phase = (byte_in == CH_T) ? PH_T2 : PH_FAIL;
      PH_T2:    nxt.phase = (byte_in == CH_T) ? PH_P : PH_FAIL;
      PH_P:     nxt.phase = (byte_in == CH_P) ? PH_SLASH : PH_FAIL;
      PH_SLASH: nxt.phase = (byte_in == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
      PH_MAJ0, PH_MAJ: begin
        if (dig) begin
          nxt.major = sat_digit(cur.major, dval);
          nxt.phase = PH_MAJ;
        end else if (byte_in == CH_DOT && cur.phase == PH_MAJ) begin
          nxt.phase = PH_MIN0;
        end else begin
          nxt.phase = PH_FAIL;
        end
      end
      PH_MIN0, PH_MIN: begin
        if (dig) begin
          nxt.minor = sat_digit(cur.minor, dval);
          nxt.phase = PH_MIN;
        end else begin
          nxt.phase = PH_FAIL;
        end
      end
      default:  nxt.phase = PH_FAIL;
    endcase
  end

endmodule

// ===== sv/http_request_line_parser.sv =====
// Top level of the HTTP request-line parser: byte register, line state, result register.
// Order: an accepted byte is registered in byte_r, then updates the line state registers;
// the byte after a CR closes the line, and once it is taken its result is registered and shown on out_valid.
// Throughput: one byte per cycle; a byte that closes a line stalls only while the
// result register is full and out_ready is low.
// Reset (rst_n low, synchronous) empties both registers and clears all line state.
module http_request_line_parser import rlp_pkg::*; #(
  parameter int MAX_LINE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [RES_W-1:0] out_method_len,
  output logic [RES_W-1:0] out_resource_start,
  output logic [RES_W-1:0] out_resource_end,
  output logic [VER_W-1:0] out_major_version,
  output logic [VER_W-1:0] out_minor_version
);

  localparam int               POS_W   = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);

  logic [7:0]       byte_r;
  logic             byte_vld_r, byte_vld_nxt;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] first_sp_r, first_sp_nxt;
  logic             sp_seen_r, sp_seen_nxt;
  logic [POS_W-1:0] last_sp_r, last_sp_nxt;
  logic [POS_W-1:0] rs_at_r, rs_at_nxt;
  logic             rs_found_r, rs_found_nxt;
  logic [POS_W-1:0] ns_end_r, ns_end_nxt;
  logic [POS_W-1:0] re_at_r, re_at_nxt;
  ver_t             ver_r, ver_nxt, ver_step;
  logic             cr_pend_r, cr_pend_nxt;
  logic             ovf_r, ovf_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [2:0]       status_r;
  logic [RES_W-1:0] method_len_r, rs_out_r, re_out_r;
  logic [VER_W-1:0] major_r, minor_r;

  logic             take;
  logic             emit;
  logic [2:0]       status;

  assign take     = byte_vld_r && !(cr_pend_r && out_vld_r && !out_ready);
  assign emit     = take && cr_pend_r;
  assign in_ready = !byte_vld_r || take;

  rlp_version u_version (
    .cur     (ver_r),
    .byte_in (byte_r),
    .nxt     (ver_step)
  );

  always_comb begin
    if (byte_r != CH_LF) begin
      status = ST_NO_LF;
    end else if (ovf_r) begin
      status = ST_LONG;
    end else if (!sp_seen_r || first_sp_r == last_sp_r) begin
      status = ST_SPACING;
    end else if (ver_r.phase != PH_MIN) begin
      status = ST_VERSION;
    end else if (!rs_found_r || rs_at_r >= last_sp_r) begin
      status = ST_SPACING;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_valid && in_ready) begin
      byte_vld_nxt = 1'b1;
    end else if (take) begin
      byte_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    first_sp_nxt = first_sp_r;
    sp_seen_nxt  = sp_seen_r;
    last_sp_nxt  = last_sp_r;
    rs_at_nxt    = rs_at_r;
    rs_found_nxt = rs_found_r;
    ns_end_nxt   = ns_end_r;
    re_at_nxt    = re_at_r;
    ver_nxt      = ver_r;
    cr_pend_nxt  = cr_pend_r;
    ovf_nxt      = ovf_r;
    if (take) begin
      if (cr_pend_r) begin
        pos_nxt       = '0;
        first_sp_nxt  = '0;
        sp_seen_nxt   = 1'b0;
        last_sp_nxt   = '0;
        rs_at_nxt     = '0;
        rs_found_nxt  = 1'b0;
        ns_end_nxt    = '0;
        re_at_nxt     = '0;
        ver_nxt.phase = PH_FAIL;
        ver_nxt.major = '0;
        ver_nxt.minor = '0;
        cr_pend_nxt   = 1'b0;
        ovf_nxt       = 1'b0;
      end else if (byte_r == CH_CR) begin
        cr_pend_nxt = 1'b1;
      end else if (pos_r >= MAX_POS) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (byte_r == CH_SP) begin
          if (!sp_seen_r) begin
            first_sp_nxt = pos_r;
            sp_seen_nxt  = 1'b1;
          end
          last_sp_nxt   = pos_r;
          re_at_nxt     = ns_end_r;
          ver_nxt.phase = PH_H1;
          ver_nxt.major = '0;
          ver_nxt.minor = '0;
        end else begin
          ns_end_nxt = pos_r + 1'b1;
          if (sp_seen_r && !rs_found_r) begin
            rs_at_nxt    = pos_r;
            rs_found_nxt = 1'b1;
          end
          ver_nxt = ver_step;
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r  <= 1'b0;
      pos_r       <= '0;
      first_sp_r  <= '0;
      sp_seen_r   <= 1'b0;
      last_sp_r   <= '0;
      rs_at_r     <= '0;
      rs_found_r  <= 1'b0;
      ns_end_r    <= '0;
      re_at_r     <= '0;
      ver_r.phase <= PH_FAIL;
      ver_r.major <= '0;
      ver_r.minor <= '0;
      cr_pend_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      byte_vld_r  <= byte_vld_nxt;
      pos_r       <= pos_nxt;
      first_sp_r  <= first_sp_nxt;
      sp_seen_r   <= sp_seen_nxt;
      last_sp_r   <= last_sp_nxt;
      rs_at_r     <= rs_at_nxt;
      rs_found_r  <= rs_found_nxt;
      ns_end_r    <= ns_end_nxt;
      re_at_r     <= re_at_nxt;
      ver_r       <= ver_nxt;
      cr_pend_r   <= cr_pend_nxt;
      ovf_r       <= ovf_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_req;
    end
    if (emit) begin
      status_r <= status;
      if (status == ST_OK) begin
        method_len_r <= RES_W'(first_sp_r);
        rs_out_r     <= RES_W'(rs_at_r);
        re_out_r     <= RES_W'(re_at_r);
        major_r      <= ver_r.major;
        minor_r      <= ver_r.minor;
      end else begin
        method_len_r <= '0;
        rs_out_r     <= '0;
        re_out_r     <= '0;
        major_r      <= '0;
        minor_r      <= '0;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = status_r;
  assign out_method_len     = method_len_r;
  assign out_resource_start = rs_out_r;
  assign out_resource_end   = re_out_r;
  assign out_major_version  = major_r;
  assign out_minor_version  = minor_r;

`ifndef ASSERT_OFF
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (!cr_pend_r && pos_r == '0 && !sp_seen_r && !ovf_r))
    else $error("line state not cleared after result");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("position beyond line limit");

  a_res_after_space: assert property (@(posedge clk) disable iff (!rst_n)
    rs_found_r |-> (sp_seen_r && rs_at_r > first_sp_r))
    else $error("resource start without preceding space");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r != ST_OK) |->
      (method_len_r == '0 && rs_out_r == '0 && re_out_r == '0 &&
       major_r == '0 && minor_r == '0))
    else $error("error result carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_vld_r && !take) |=> (byte_vld_r && $stable(byte_r)))
    else $error("stalled byte lost");
`endif

endmodule
